// File: sv/gha_pkg.sv
// Shared types and constants of the generational handle allocator.
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

    localparam int unsigned IDX_BITS = 10;
    localparam int unsigned TAG_OUT_BITS = 32;
    localparam int unsigned CNT_OUT_BITS = 11;

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_STALE = 2'd1,
        ST_FULL  = 2'd2,
        ST_NEVER = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_REMOVE,
        OP_LOOKUP
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ALLOC,
        BK_CHECK
    } t_back_state;

    typedef struct packed {
        logic [1:0]              action;
        logic [IDX_BITS-1:0]     slot_index;
        logic [TAG_OUT_BITS-1:0] handle_tag;
    } t_in_word;

    typedef struct packed {
        t_status                 status;
        logic [IDX_BITS-1:0]     result_index;
        logic [TAG_OUT_BITS-1:0] result_tag;
        logic [CNT_OUT_BITS-1:0] live_count;
    } t_out_word;

    // Classified command as it sits in the queue between front and back.
    typedef struct packed {
        t_op                     op;
        logic [IDX_BITS-1:0]     slot_index;
        logic [TAG_OUT_BITS-1:0] handle_tag;
    } t_cmd;

    // Control decisions of the back sequencer for one cycle.
    typedef struct packed {
        logic    pop;
        logic    take_stack;
        logic    take_hw;
        logic    stk_push;
        logic    tag_rd;
        logic    tag_wr;
        logic    tag_live;
        logic    emit;
        t_status status;
    } t_back_ctl;

endpackage

`default_nettype wire

// File: sv/gha_front.sv
// Front end: decodes incoming words and holds them in a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none

module gha_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire gha_pkg::t_in_word i_word,
    output logic                   o_valid,
    output gha_pkg::t_cmd          o_cmd,
    input  wire logic              i_pop
);

    gha_pkg::t_cmd r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    gha_pkg::t_cmd dec_cmd;
    logic          push;
    logic          pop;

    always_comb begin
        dec_cmd.slot_index = i_word.slot_index;
        dec_cmd.handle_tag = i_word.handle_tag;
        // The unused action code behaves as a lookup.
        unique case (i_word.action)
            gha_pkg::ACT_ALLOC:  dec_cmd.op = gha_pkg::OP_ALLOC;
            gha_pkg::ACT_REMOVE: dec_cmd.op = gha_pkg::OP_REMOVE;
            default:             dec_cmd.op = gha_pkg::OP_LOOKUP;
        endcase
    end

    assign busy    = (r_count == 2'd2);
    assign push    = start && !busy;
    assign o_valid = (r_count != 2'd0);
    assign pop     = i_pop && o_valid;
    assign o_cmd   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/gha_back.sv
// Back end: slot table, free stack and counters, one command at a time.
`timescale 1ns / 1ps
`default_nettype none

module gha_back #(
    parameter int unsigned SLOTS    = 1024,
    parameter int unsigned TAG_BITS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire gha_pkg::t_cmd   i_cmd,
    output logic                 o_pop,
    output logic                 o_strobe,
    output gha_pkg::t_out_word   o_result
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(SLOTS + 1);
    localparam int unsigned CMP_W = (CNT_W > gha_pkg::CNT_OUT_BITS) ? CNT_W
                                                                   : gha_pkg::CNT_OUT_BITS;
    localparam int unsigned TW    = (TAG_BITS > gha_pkg::TAG_OUT_BITS) ? TAG_BITS
                                                                      : gha_pkg::TAG_OUT_BITS;

    // Slot table word: live bit above the tag.
    logic [TAG_BITS:0]   tag_mem [SLOTS];
    logic [IDX_W-1:0]    stk_mem [SLOTS];

    gha_pkg::t_back_state r_state, n_state;
    gha_pkg::t_back_ctl   ctl;
    gha_pkg::t_cmd        r_cmd;
    logic [CNT_W-1:0]     r_free_depth, n_free_depth;
    logic [CNT_W-1:0]     r_high_water, n_high_water;
    logic [TAG_BITS-1:0]  r_tag_ctr, n_tag_ctr;
    logic [IDX_W-1:0]     r_slot;
    logic                 r_from_stack;
    logic [IDX_W-1:0]     r_stk_q;
    logic [TAG_BITS:0]    r_tag_q;
    logic                 r_strobe;
    gha_pkg::t_out_word   r_result, n_result;

    logic [CMP_W-1:0]     q_idx_ext, c_idx_ext, hw_ext;
    logic                 free_nz, hw_room, in_range, tag_match;
    logic [TW-1:0]        stored_tag_ext, ctr_ext;
    logic [IDX_W-1:0]     alloc_slot, tag_wr_addr;
    logic [TAG_BITS:0]    tag_wr_data;
    logic [CNT_W-1:0]     live_now;
    logic [CMP_W-1:0]     live_ext, slot_ext;

    assign q_idx_ext      = CMP_W'(i_cmd.slot_index);
    assign c_idx_ext      = CMP_W'(r_cmd.slot_index);
    assign hw_ext         = CMP_W'(r_high_water);
    assign free_nz        = (r_free_depth != '0);
    assign hw_room        = (r_high_water < CNT_W'(SLOTS));
    assign in_range       = (q_idx_ext < hw_ext);
    assign stored_tag_ext = TW'(r_tag_q[TAG_BITS-1:0]);
    assign ctr_ext        = TW'(r_tag_ctr);
    assign tag_match      = r_tag_q[TAG_BITS] &&
                            (stored_tag_ext[gha_pkg::TAG_OUT_BITS-1:0] == r_cmd.handle_tag);
    assign alloc_slot     = r_from_stack ? r_stk_q : r_slot;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gha_pkg::BK_IDLE: begin
                if (i_valid) begin
                    if (i_cmd.op == gha_pkg::OP_ALLOC) begin
                        if (free_nz || hw_room) begin
                            n_state = gha_pkg::BK_ALLOC;
                        end
                    end else if (in_range) begin
                        n_state = gha_pkg::BK_CHECK;
                    end
                end
            end
            gha_pkg::BK_ALLOC: n_state = gha_pkg::BK_IDLE;
            gha_pkg::BK_CHECK: n_state = gha_pkg::BK_IDLE;
            default:           n_state = gha_pkg::BK_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        ctl = '{default: '0, status: gha_pkg::ST_OK};
        unique case (r_state)
            gha_pkg::BK_IDLE: begin
                if (i_valid) begin
                    ctl.pop = 1'b1;
                    if (i_cmd.op == gha_pkg::OP_ALLOC) begin
                        if (free_nz) begin
                            ctl.take_stack = 1'b1;
                        end else if (hw_room) begin
                            ctl.take_hw = 1'b1;
                        end else begin
                            ctl.emit   = 1'b1;
                            ctl.status = gha_pkg::ST_FULL;
                        end
                    end else if (in_range) begin
                        ctl.tag_rd = 1'b1;
                    end else begin
                        ctl.emit   = 1'b1;
                        ctl.status = gha_pkg::ST_NEVER;
                    end
                end
            end
            gha_pkg::BK_ALLOC: begin
                ctl.tag_wr   = 1'b1;
                ctl.tag_live = 1'b1;
                ctl.emit     = 1'b1;
            end
            gha_pkg::BK_CHECK: begin
                ctl.emit = 1'b1;
                if (tag_match) begin
                    if (r_cmd.op == gha_pkg::OP_REMOVE) begin
                        ctl.tag_wr   = 1'b1;
                        ctl.stk_push = (r_free_depth < CNT_W'(SLOTS));
                    end
                end else begin
                    ctl.status = gha_pkg::ST_STALE;
                end
            end
            default: ;
        endcase
    end

    // Datapath updates and the result word.
    always_comb begin
        n_free_depth = r_free_depth;
        n_high_water = r_high_water;
        n_tag_ctr    = r_tag_ctr;
        if (ctl.take_stack) begin
            n_free_depth = r_free_depth - CNT_W'(1);
        end else if (ctl.stk_push) begin
            n_free_depth = r_free_depth + CNT_W'(1);
        end
        if (ctl.take_hw) begin
            n_high_water = r_high_water + CNT_W'(1);
        end
        if (ctl.tag_wr && ctl.tag_live) begin
            n_tag_ctr = r_tag_ctr + TAG_BITS'(1);
        end

        // An allocate writes a fresh live tag; a remove keeps the tag and clears live.
        tag_wr_addr = ctl.tag_live ? alloc_slot : c_idx_ext[IDX_W-1:0];
        tag_wr_data = ctl.tag_live ? {1'b1, r_tag_ctr} : {1'b0, r_tag_q[TAG_BITS-1:0]};

        live_now = n_high_water - n_free_depth;
        live_ext = CMP_W'(live_now);
        slot_ext = CMP_W'(alloc_slot);

        n_result.status       = ctl.status;
        n_result.result_index = '0;
        n_result.result_tag   = '0;
        n_result.live_count   = live_ext[gha_pkg::CNT_OUT_BITS-1:0];
        if (ctl.status == gha_pkg::ST_OK) begin
            if (r_state == gha_pkg::BK_ALLOC) begin
                n_result.result_index = slot_ext[gha_pkg::IDX_BITS-1:0];
                n_result.result_tag   = ctr_ext[gha_pkg::TAG_OUT_BITS-1:0];
            end else begin
                n_result.result_index = r_cmd.slot_index;
                n_result.result_tag   = stored_tag_ext[gha_pkg::TAG_OUT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.tag_wr) begin
            tag_mem[tag_wr_addr] <= tag_wr_data;
        end
        if (ctl.tag_rd) begin
            r_tag_q <= tag_mem[q_idx_ext[IDX_W-1:0]];
        end
        if (ctl.stk_push) begin
            stk_mem[r_free_depth[IDX_W-1:0]] <= c_idx_ext[IDX_W-1:0];
        end
        if (ctl.take_stack) begin
            r_stk_q <= stk_mem[n_free_depth[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.pop) begin
            r_cmd        <= i_cmd;
            r_from_stack <= ctl.take_stack;
            r_slot       <= r_high_water[IDX_W-1:0];
        end
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gha_pkg::BK_IDLE;
            r_free_depth <= '0;
            r_high_water <= '0;
            r_tag_ctr    <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_depth <= n_free_depth;
            r_high_water <= n_high_water;
            r_tag_ctr    <= n_tag_ctr;
            r_strobe     <= ctl.emit;
        end
    end

    assign o_pop    = ctl.pop;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: sv/generational_handle_allocator_top.sv
// Top level of the generational handle allocator.
//
//  channel  | ports                        | handshake
//  ---------+------------------------------+----------------------------------
//  command  | i_word (t_in_word)           | taken when start high, busy low
//  result   | o_result (t_out_word)        | one cycle, marked by o_strobe
//
// An allocate, remove or lookup that touches the slot table goes from the idle
// state to the alloc or check state, which uses the registered read of the
// slot table or free stack; a result from the counters alone (pool full, index
// never allocated) is decided in idle. Result and o_strobe are registered.
// A two-word queue sits between front and back; busy is high while it is full.
// Reset is synchronous, active low, and clears the queue, counters and state;
// the slot table and free stack need no clearing. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_allocator_top #(
    parameter int unsigned SLOTS    = 1024,
    parameter int unsigned TAG_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire gha_pkg::t_in_word  i_word,
    output logic                    o_strobe,
    output gha_pkg::t_out_word      o_result
);

    logic          q_valid;
    gha_pkg::t_cmd q_cmd;
    logic          q_pop;

    gha_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_word  (i_word),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    gha_back #(
        .SLOTS    (SLOTS),
        .TAG_BITS (TAG_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cmd    (q_cmd),
        .o_pop    (q_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// File: sv/gha_checker.sv
// Port-level checks of the handle allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gha_checker #(
    parameter int unsigned SLOTS = 1024
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               busy,
    input wire logic               o_strobe,
    input wire gha_pkg::t_out_word o_result
);

    // Busy is low and nothing is reported in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("result or busy right after reset");

    // A failed word carries a zero handle.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status != gha_pkg::ST_OK)
        |-> (o_result.result_index == '0) && (o_result.result_tag == '0))
        else $error("failed word carries a handle");

    // The pool reports full only when every slot is live.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status == gha_pkg::ST_FULL)
        |-> (o_result.live_count == gha_pkg::CNT_OUT_BITS'(SLOTS)))
        else $error("pool full with free slots");

    // The live count never exceeds the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (32'(o_result.live_count) <= SLOTS))
        else $error("live count beyond table size");

endmodule

bind generational_handle_allocator_top gha_checker #(
    .SLOTS (SLOTS)
) u_gha_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire

// File: bench/generational_handle_allocator_top_tb.sv
// Self-checking testbench for the handle allocator: directed table, then random traffic.
`timescale 1ns / 1ps

module generational_handle_allocator_top_tb;

    localparam int unsigned NUM_SLOTS = 1024;
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int unsigned RETIRED_KEEP = 64;

    typedef struct {
        logic [1:0]       act;
        logic [9:0]       idx;
        logic [31:0]      tag;
        bit               typed;
        gha_pkg::t_status want_status;
        logic [9:0]       want_index;
        logic [31:0]      want_tag;
        logic [10:0]      want_count;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    gha_pkg::t_in_word  i_word = '0;
    logic               o_strobe;
    gha_pkg::t_out_word o_result;

    // Mirror of the allocator state.
    logic [31:0] slot_tag_copy [NUM_SLOTS];
    bit          slot_live_copy [NUM_SLOTS];
    logic [9:0]  free_slots [NUM_SLOTS];
    int unsigned free_count = 0;
    int unsigned hand_out_mark = 0;
    logic [31:0] next_tag = '0;

    gha_pkg::t_out_word owed_results [$];
    logic [9:0]         live_slots [$];
    gha_pkg::t_in_word  retired_handles [$];
    int unsigned        fail_count = 0;
    int unsigned        gap_ceiling = 8;

    t_stim_row stim_table [21] = '{
        '{gha_pkg::ACT_LOOKUP, 10'd0,    32'h0,        1'b1, gha_pkg::ST_NEVER,
          10'd0, 32'h0, 11'd0},
        '{gha_pkg::ACT_REMOVE, 10'd1023, 32'hffffffff, 1'b1, gha_pkg::ST_NEVER,
          10'd0, 32'h0, 11'd0},
        '{ACT_SPARE,           10'd0,    32'h0,        1'b1, gha_pkg::ST_NEVER,
          10'd0, 32'h0, 11'd0},
        '{gha_pkg::ACT_ALLOC,  10'd0,    32'h0,        1'b1, gha_pkg::ST_OK,
          10'd0, 32'h0, 11'd1},
        '{gha_pkg::ACT_ALLOC,  10'd1023, 32'hffffffff, 1'b1, gha_pkg::ST_OK,
          10'd1, 32'h1, 11'd2},
        '{gha_pkg::ACT_LOOKUP, 10'd0,    32'h0,        1'b0, gha_pkg::ST_OK,
          10'd0, 32'h0, 11'd0},
        '{gha_pkg::ACT_LOOKUP, 10'd0,    32'hffffffff, 1'b1, gha_pkg::ST_STALE,
          10'd0, 32'h0, 11'd2},
        '{ACT_SPARE,           10'd1,    32'h1,        1'b0, gha_pkg::ST_OK,
          10'd0, 32'h0, 11'd0},
        '{gha_pkg::ACT_REMOVE, 10'd1,    32'h1,        1'b0, gha_pkg::ST_OK,
          10'd0, 32'h0, 11'd0},
        '{gha_pkg::ACT_REMOVE, 10'd1,    32'h1,        1'b1, gha_pkg::ST_STALE,
          10'd0, 32'h0, 11'd1},
        '{gha_pkg::ACT_LOOKUP, 10'd1,    32'h1,        1'b1, gha_pkg::ST_STALE,
          10'd0, 32'h0, 11'd1},
        '{gha_pkg::ACT_LOOKUP, 10'd2,    32'h0,        1'b1, gha_pkg::ST_NEVER,
          10'd0, 32'h0, 11'd1},
        '{gha_pkg::ACT_ALLOC,  10'd0,    32'h0,        1'b0, gha_pkg::ST_OK,
          10'd0, 32'h0, 11'd0},
        '{gha_pkg::ACT_REMOVE, 10'd1,    32'h1,        1'b1, gha_pkg::ST_STALE,
          10'd0, 32'h0, 11'd2},
        '{gha_pkg::ACT_REMOVE, 10'd0,    32'h0,        1'b0, gha_pkg::ST_OK,
          10'd0, 32'h0, 11'd0},
        '{gha_pkg::ACT_REMOVE, 10'd1,    32'h2,        1'b0, gha_pkg::ST_OK,
          10'd0, 32'h0, 11'd0},
        '{gha_pkg::ACT_ALLOC,  10'd0,    32'h0,        1'b0, gha_pkg::ST_OK,
          10'd0, 32'h0, 11'd0},
        '{gha_pkg::ACT_ALLOC,  10'd0,    32'h0,        1'b0, gha_pkg::ST_OK,
          10'd0, 32'h0, 11'd0},
        '{gha_pkg::ACT_ALLOC,  10'd0,    32'h0,        1'b0, gha_pkg::ST_OK,
          10'd0, 32'h0, 11'd0},
        '{gha_pkg::ACT_LOOKUP, 10'd1023, 32'h0,        1'b1, gha_pkg::ST_NEVER,
          10'd0, 32'h0, 11'd3},
        '{gha_pkg::ACT_LOOKUP, 10'd2,    32'h5,        1'b0, gha_pkg::ST_OK,
          10'd0, 32'h0, 11'd0}
    };

    generational_handle_allocator_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_word   (i_word),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 100) begin
            $display("MISMATCH at %0t ns: %s got %0h want %0h", $time, what, got, want);
        end
        fail_count++;
    endtask

    // Works out the result word of one command and advances the mirrored state.
    function automatic gha_pkg::t_out_word allocator_step(input gha_pkg::t_in_word w);
        gha_pkg::t_out_word r;
        logic [9:0]         slot;
        r = '0;
        r.status = gha_pkg::ST_OK;
        slot = '0;
        if (w.action == gha_pkg::ACT_ALLOC) begin
            if (free_count > 0) begin
                free_count--;
                slot = free_slots[free_count];
            end else if (hand_out_mark < NUM_SLOTS) begin
                slot = hand_out_mark[9:0];
                hand_out_mark++;
            end else begin
                r.status = gha_pkg::ST_FULL;
            end
            if (r.status == gha_pkg::ST_OK) begin
                slot_tag_copy[slot] = next_tag;
                slot_live_copy[slot] = 1'b1;
                r.result_index = slot;
                r.result_tag = next_tag;
                next_tag = next_tag + 32'd1;
            end
        end else if (w.slot_index >= hand_out_mark) begin
            r.status = gha_pkg::ST_NEVER;
        end else if (!slot_live_copy[w.slot_index]
                     || slot_tag_copy[w.slot_index] != w.handle_tag) begin
            r.status = gha_pkg::ST_STALE;
        end else begin
            if (w.action == gha_pkg::ACT_REMOVE) begin
                slot_live_copy[w.slot_index] = 1'b0;
                free_slots[free_count] = w.slot_index;
                free_count++;
            end
            r.result_index = w.slot_index;
            r.result_tag = slot_tag_copy[w.slot_index];
        end
        r.live_count = 11'(hand_out_mark - free_count);
        return r;
    endfunction

    // Keeps the lists of live and retired handles that the random traffic draws on.
    function automatic void track_handles(input gha_pkg::t_in_word w,
                                          input gha_pkg::t_out_word r);
        int pos;
        pos = -1;
        if (r.status == gha_pkg::ST_OK && w.action == gha_pkg::ACT_ALLOC) begin
            live_slots.insert(live_slots.size(), r.result_index);
        end else if (r.status == gha_pkg::ST_OK && w.action == gha_pkg::ACT_REMOVE) begin
            for (int i = 0; i < live_slots.size(); i++) begin
                if (live_slots[i] == r.result_index) begin
                    pos = i;
                end
            end
            if (pos >= 0) begin
                live_slots.delete(pos);
            end
            retired_handles.insert(retired_handles.size(), w);
            if (retired_handles.size() > RETIRED_KEEP) begin
                void'(retired_handles.pop_front());
            end
        end
    endfunction

    function automatic gha_pkg::t_in_word pick_word(input int unsigned alloc_pct);
        gha_pkg::t_in_word w;
        gha_pkg::t_in_word old;
        int unsigned       roll;
        logic [9:0]        slot;
        w.action = gha_pkg::ACT_ALLOC;
        w.slot_index = 10'($urandom);
        w.handle_tag = $urandom;
        roll = $urandom_range(99);
        if (roll < alloc_pct || live_slots.size() == 0) begin
            return w;
        end
        roll = $urandom_range(99);
        slot = live_slots[$urandom_range(live_slots.size() - 1)];
        if (roll < 45) begin
            w.action = gha_pkg::ACT_REMOVE;
            w.slot_index = slot;
            w.handle_tag = slot_tag_copy[slot];
        end else if (roll < 70) begin
            w.action = $urandom_range(1) ? gha_pkg::ACT_LOOKUP : ACT_SPARE;
            w.slot_index = slot;
            w.handle_tag = slot_tag_copy[slot];
        end else if (roll < 85) begin
            // A handle whose slot has since been freed or re-stamped, or a live
            // slot with one tag bit flipped.
            w.action = $urandom_range(1) ? gha_pkg::ACT_REMOVE : gha_pkg::ACT_LOOKUP;
            if (retired_handles.size() != 0 && $urandom_range(1)) begin
                old = retired_handles[$urandom_range(retired_handles.size() - 1)];
                w.slot_index = old.slot_index;
                w.handle_tag = old.handle_tag;
            end else begin
                w.slot_index = slot;
                w.handle_tag = slot_tag_copy[slot] ^ (32'd1 << $urandom_range(31));
            end
        end else begin
            w.action = 2'($urandom_range(3, 1));
        end
        return w;
    endfunction

    // Presents one word, waits for it to be taken and records the expected result.
    // Returns at a falling edge at which start has not yet been driven.
    task automatic send_word(input gha_pkg::t_in_word w, input bit typed,
                             input gha_pkg::t_out_word want);
        gha_pkg::t_out_word predicted;
        gha_pkg::t_out_word expected;
        int unsigned        gap;
        start <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
        predicted = allocator_step(w);
        expected = typed ? want : predicted;
        owed_results.insert(owed_results.size(), expected);
        track_handles(w, predicted);
        gap = $urandom_range(gap_ceiling);
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            i_word <= '{action: 2'($urandom), slot_index: 10'($urandom),
                        handle_tag: $urandom};
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (owed_results.size() != 0);
    endtask

    always @(posedge i_clk) begin : result_check
        gha_pkg::t_out_word want;
        if (i_rst_n && o_strobe) begin
            if (owed_results.size() == 0) begin
                report_mismatch("result word with nothing outstanding",
                                o_result.result_tag, 32'h0);
            end else begin
                want = owed_results.pop_front();
                if (o_result.status !== want.status) begin
                    report_mismatch("status", 32'(o_result.status), 32'(want.status));
                end
                if (o_result.result_index !== want.result_index) begin
                    report_mismatch("result_index", 32'(o_result.result_index),
                                    32'(want.result_index));
                end
                if (o_result.result_tag !== want.result_tag) begin
                    report_mismatch("result_tag", o_result.result_tag, want.result_tag);
                end
                if (o_result.live_count !== want.live_count) begin
                    report_mismatch("live_count", 32'(o_result.live_count),
                                    32'(want.live_count));
                end
            end
        end
    end

    initial begin : stimulus
        gha_pkg::t_in_word  w;
        gha_pkg::t_out_word want;
        int unsigned        waited;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_table[n]) begin
            w.action = stim_table[n].act;
            w.slot_index = stim_table[n].idx;
            w.handle_tag = stim_table[n].tag;
            want.status = stim_table[n].want_status;
            want.result_index = stim_table[n].want_index;
            want.result_tag = stim_table[n].want_tag;
            want.live_count = stim_table[n].want_count;
            send_word(w, stim_table[n].typed, want);
        end
        wait_until_drained();

        // Mixed traffic with few live handles, the first stretch back to back.
        for (int n = 0; n < 250; n++) begin
            gap_ceiling = (n < 80) ? 0 : 8;
            send_word(pick_word(live_slots.size() > 48 ? 20 : 40), 1'b0, '0);
        end

        // Fill the pool, then knock on it a few times while it is full.
        gap_ceiling = 8;
        while (hand_out_mark < NUM_SLOTS || free_count != 0) begin
            send_word(pick_word(92), 1'b0, '0);
        end
        gap_ceiling = 0;
        for (int n = 0; n < 6; n++) begin
            send_word(pick_word(100), 1'b0, '0);
        end
        wait_until_drained();

        // Mostly removes and lookups; freed slots come back in last-in, first-out order.
        for (int n = 0; n < 250; n++) begin
            gap_ceiling = (n >= 190) ? 0 : 8;
            send_word(pick_word(20), 1'b0, '0);
        end

        start <= 1'b0;
        waited = 0;
        while (owed_results.size() != 0 && waited < 2000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (10) @(negedge i_clk);
        if (owed_results.size() != 0) begin
            report_mismatch("result words never delivered", 32'(owed_results.size()), 32'h0);
        end
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
